[rtl/mrfc_pkg.sv]
// Shared types, constants and the byte-wide CRC step for the Modbus reply checker.
// No dependencies; used by every module in rtl.
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam int unsigned NUM_SLAVES_DEF = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;

  localparam logic [15:0] LEN_FLOW  = 16'h0004;
  localparam logic [15:0] LEN_TOTAL = 16'h0008;
  localparam logic [15:0] LEN_UNIT  = 16'h0002;

  // lowest byte index the last byte may sit at for each kind
  localparam logic [3:0]  LAST_IDX_FLOW  = 4'd9;
  localparam logic [3:0]  LAST_IDX_TOTAL = 4'd13;
  localparam logic [3:0]  LAST_IDX_UNIT  = 4'd7;

  localparam logic [3:0]  COUNT_MAX = 4'd15;

  localparam logic [3:0]  IDX_ADDR   = 4'd0;
  localparam logic [3:0]  IDX_FUNC   = 4'd1;
  localparam logic [3:0]  IDX_LEN_HI = 4'd2;
  localparam logic [3:0]  IDX_LEN_LO = 4'd3;
  localparam logic [3:0]  IDX_W0_LO  = 4'd4;
  localparam logic [3:0]  IDX_W0_HI  = 4'd7;
  localparam logic [3:0]  IDX_W1_LO  = 4'd8;
  localparam logic [3:0]  IDX_W1_HI  = 4'd11;
  localparam logic [3:0]  IDX_UNIT   = 4'd5;

  typedef enum logic [1:0] {
    KIND_FLOW_FLOAT = 2'd0,
    KIND_TOTAL_LONG = 2'd1,
    KIND_FLOW_UNIT  = 2'd2,
    KIND_TOTAL_UNIT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_BAD_FUNC  = 3'd2,
    ST_BAD_CRC   = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_TOO_SHORT = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
  } beat_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slave_index;
    kind_t       kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [7:0]  unit_code;
  } result_t;

  typedef struct packed {
    logic update;
    logic clear;
  } crc_ctl_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/modbus_response_frame_checker.sv]
// Top level of the Modbus RTU reply checker: input register, frame logic, result register.
// Depends on mrfc_pkg, mrfc_frame and mrfc_crc.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one reply byte per beat with
//   last_byte set on the final CRC byte and frame_kind naming the reply type;
//   the kind given with the last byte decides the check.
//   Output channel (out_valid / out_stall) carries one result per frame: status,
//   slave_index, kind_out, first_word, second_word and unit_code.
//   Throughput: one byte per cycle when not stalled; CRC folds a whole byte per update.
//   Path: the last byte of a frame goes into the input register; its result is
//   then loaded into the result register and shown on the output, once a stalled
//   earlier result has moved on.
//   Bytes that are not last give no result.
//   A stalled result holds on the output; the input register still takes a
//   byte while it is empty, then in_stall rises until the result moves on.
//   Reset (rst, synchronous) empties both registers and restarts the frame:
//   CRC reloads to 0xFFFF and the byte count returns to zero.
//   After every last byte the frame state restarts the same way.
`timescale 1ns / 1ps

module modbus_response_frame_checker #(
  parameter int unsigned NUM_SLAVES = mrfc_pkg::NUM_SLAVES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  input  logic [1:0]  frame_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  slave_index,
  output logic [1:0]  kind_out,
  output logic [31:0] first_word,
  output logic [31:0] second_word,
  output logic [7:0]  unit_code
);

  logic               s1_valid;
  mrfc_pkg::beat_t    s1;
  logic               advance;
  logic               fire;
  mrfc_pkg::result_t  frame_result;
  mrfc_pkg::result_t  res;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1.data <= rx_byte;
      s1.last <= last_byte;
      s1.kind <= mrfc_pkg::kind_t'(frame_kind);
    end
  end

  mrfc_frame #(
    .NUM_SLAVES (NUM_SLAVES)
  ) u_frame (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .beat   (s1),
    .result (frame_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && s1.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1.last) begin
      res <= frame_result;
    end
  end

  assign status      = res.status;
  assign slave_index = res.slave_index;
  assign kind_out    = res.kind;
  assign first_word  = res.first_word;
  assign second_word = res.second_word;
  assign unit_code   = res.unit_code;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && s1.last |=> out_valid)
    else $error("last beat did not produce a result");

  a_fail_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != mrfc_pkg::ST_OK |->
      first_word == '0 && second_word == '0 && unit_code == '0 && slave_index == '0)
    else $error("failed frame carries data");

  a_float_no_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res.kind == mrfc_pkg::KIND_FLOW_FLOAT ||
                  res.kind == mrfc_pkg::KIND_TOTAL_LONG) |-> unit_code == '0)
    else $error("unit code on a float frame");

endmodule

[rtl/mrfc_crc.sv]
// CRC-16 accumulator: one byte folded in per update, reloaded on clear.
// Depends on mrfc_pkg.
`timescale 1ns / 1ps

module mrfc_crc (
  input  logic                clk,
  input  logic                rst,
  input  mrfc_pkg::crc_ctl_t  ctl,
  input  logic [7:0]          data,
  output logic [15:0]         crc_next
);

  logic [15:0] crc;

  assign crc_next = ctl.update ? mrfc_pkg::crc_byte(crc, data) : crc;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      crc <= mrfc_pkg::CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

[rtl/mrfc_frame.sv]
// Frame state and result evaluation for one registered beat.
// Depends on mrfc_pkg and mrfc_crc.
`timescale 1ns / 1ps

module mrfc_frame #(
  parameter int unsigned NUM_SLAVES = mrfc_pkg::NUM_SLAVES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mrfc_pkg::beat_t     beat,
  output mrfc_pkg::result_t   result
);

  localparam logic [7:0] MAX_ADDR = 8'(NUM_SLAVES);

  logic [3:0]         byte_count;
  logic [7:0]         tail0;
  logic [7:0]         tail1;
  logic [7:0]         addr_byte;
  logic               func_ok;
  logic [15:0]        length_field;
  logic [31:0]        word0;
  logic [31:0]        word1;
  logic [7:0]         unit_byte;
  logic [15:0]        crc_next;
  mrfc_pkg::crc_ctl_t crc_ctl;
  logic [3:0]         min_idx;
  logic [15:0]        expect_len;
  logic [15:0]        rx_crc;
  logic [7:0]         addr_m1;

  assign crc_ctl.update = fire && (byte_count >= mrfc_pkg::IDX_LEN_HI);
  assign crc_ctl.clear  = fire && beat.last;

  mrfc_crc u_crc (
    .clk      (clk),
    .rst      (rst),
    .ctl      (crc_ctl),
    .data     (tail0),
    .crc_next (crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (fire) begin
      if (beat.last) begin
        byte_count <= '0;
      end else if (byte_count != mrfc_pkg::COUNT_MAX) begin
        byte_count <= byte_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tail0 <= tail1;
      tail1 <= beat.data;
      if (byte_count == mrfc_pkg::IDX_ADDR) begin
        addr_byte <= beat.data;
      end
      if (byte_count == mrfc_pkg::IDX_FUNC) begin
        func_ok <= (beat.data == mrfc_pkg::FUNC_READ_INPUT);
      end
      if (byte_count == mrfc_pkg::IDX_LEN_HI) begin
        length_field[15:8] <= beat.data;
      end
      if (byte_count == mrfc_pkg::IDX_LEN_LO) begin
        length_field[7:0] <= beat.data;
      end
      if (byte_count >= mrfc_pkg::IDX_W0_LO && byte_count <= mrfc_pkg::IDX_W0_HI) begin
        word0 <= {word0[23:0], beat.data};
      end
      if (byte_count >= mrfc_pkg::IDX_W1_LO && byte_count <= mrfc_pkg::IDX_W1_HI) begin
        word1 <= {word1[23:0], beat.data};
      end
      if (byte_count == mrfc_pkg::IDX_UNIT) begin
        unit_byte <= beat.data;
      end
    end
  end

  always_comb begin
    case (beat.kind)
      mrfc_pkg::KIND_FLOW_FLOAT: begin
        min_idx    = mrfc_pkg::LAST_IDX_FLOW;
        expect_len = mrfc_pkg::LEN_FLOW;
      end
      mrfc_pkg::KIND_TOTAL_LONG: begin
        min_idx    = mrfc_pkg::LAST_IDX_TOTAL;
        expect_len = mrfc_pkg::LEN_TOTAL;
      end
      default: begin
        min_idx    = mrfc_pkg::LAST_IDX_UNIT;
        expect_len = mrfc_pkg::LEN_UNIT;
      end
    endcase
  end

  assign rx_crc  = {beat.data, tail1};
  assign addr_m1 = addr_byte - 8'd1;

  always_comb begin
    result             = '0;
    result.kind        = beat.kind;
    result.status      = mrfc_pkg::ST_OK;
    if (byte_count < min_idx) begin
      result.status = mrfc_pkg::ST_TOO_SHORT;
    end else if (addr_byte == 8'd0 || addr_byte > MAX_ADDR) begin
      result.status = mrfc_pkg::ST_BAD_ADDR;
    end else if (!func_ok) begin
      result.status = mrfc_pkg::ST_BAD_FUNC;
    end else if (crc_next != rx_crc) begin
      result.status = mrfc_pkg::ST_BAD_CRC;
    end else if (length_field != expect_len) begin
      result.status = mrfc_pkg::ST_BAD_LEN;
    end else begin
      result.slave_index = addr_m1[2:0];
      case (beat.kind)
        mrfc_pkg::KIND_FLOW_FLOAT: begin
          result.first_word = word0;
        end
        mrfc_pkg::KIND_TOTAL_LONG: begin
          result.first_word  = word0;
          result.second_word = word1;
        end
        default: begin
          result.unit_code = unit_byte;
        end
      endcase
    end
  end

endmodule
